>>> hw/rtl/rclfr_pkg.sv
// Shared types and constants of the RC link frame receiver.
`timescale 1ns / 1ps

package rclfr_pkg;

  // Input word operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_OK   = 2'd0;
  localparam logic [1:0] KIND_DROP = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'd1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  OWN_ADDRESS_RESET = 8'd130;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd500;

  // Frame layout and CRC.
  localparam int unsigned TOTAL_W           = 9;
  localparam logic [TOTAL_W-1:0] PROV_TOTAL = 9'd5;
  localparam logic [7:0]  CRC_POLY          = 8'hD5;

  typedef struct packed {
    logic [7:0]  own_address;
    logic [15:0] timeout_us;
  } cfg_t;

  // Result descriptor from the parser to the output pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic       rd_zero;      // read index past one store half
  } res_t;

endpackage

>>> hw/rtl/rclfr_if.sv
// Stream interfaces for the input and result channels.
`timescale 1ns / 1ps

interface rclfr_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  rx_byte;
  logic [31:0] time_us;
  logic [3:0]  read_index;

  modport source (output valid, operation, rx_byte, time_us, read_index, input ready);
  modport sink   (input valid, operation, rx_byte, time_us, read_index, output ready);
endinterface

interface rclfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] frame_type;
  logic [7:0] frame_length;
  logic [7:0] read_data;

  modport source (output valid, result_kind, frame_type, frame_length, read_data,
                  input ready);
  modport sink   (input valid, result_kind, frame_type, frame_length, read_data,
                  output ready);
endinterface

>>> hw/rtl/rclfr_store.sv
// Double-buffered frame byte memory with per-entry valid bits.
`timescale 1ns / 1ps

module rclfr_store #(
  parameter int unsigned MaxFrameBytes = 14,
  localparam int unsigned Depth = 2 * MaxFrameBytes,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0]       mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [7:0]       rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else if (rd_en_i) begin
      rvld_q <= vld_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : 8'd0;

endmodule

>>> hw/rtl/rclfr_parser.sv
// Frame assembly state, timeout, CRC-8 and store access control.
`timescale 1ns / 1ps

module rclfr_parser #(
  parameter int unsigned MaxFrameBytes = 14,
  localparam int unsigned Depth = 2 * MaxFrameBytes,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned PosW = $clog2(MaxFrameBytes + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic              operation_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [31:0]       time_us_i,
  input  logic [3:0]        read_index_i,
  input  rclfr_pkg::cfg_t   cfg_i,
  output logic              wr_en_o,
  output logic [AddrW-1:0]  wr_addr_o,
  output logic [7:0]        wr_data_o,
  output logic              rd_en_o,
  output logic [AddrW-1:0]  rd_addr_o,
  output rclfr_pkg::res_t   res_o
);

  localparam logic [PosW-1:0]  PosMax   = PosW'(MaxFrameBytes);
  localparam logic [AddrW-1:0] HalfBase = AddrW'(MaxFrameBytes);
  localparam logic [6:0]       IdxLimit = 7'(MaxFrameBytes);

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ rclfr_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  logic             half_q, half_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [31:0]      start_q, start_d;
  logic [7:0]       crc_q, crc_d;
  logic [7:0]       addr_q, len_q, type_q;

  logic [31:0]               gap;
  logic                      timeout;
  logic [PosW-1:0]           pos0, pos1;
  logic [rclfr_pkg::TOTAL_W-1:0] total;
  logic                      take;
  logic                      done;
  logic                      is_byte;

  always_comb begin
    is_byte = acc_i && (operation_i == rclfr_pkg::OP_BYTE);
    gap     = time_us_i - start_q;
    timeout = !gap[31] && (gap > {16'd0, cfg_i.timeout_us});
    pos0    = timeout ? '0 : pos_q;
    total   = (pos0 < PosW'(3)) ? rclfr_pkg::PROV_TOTAL
                                : ({1'b0, len_q} + rclfr_pkg::TOTAL_W'(2));
    take    = (rclfr_pkg::TOTAL_W'(pos0) < total) && (pos0 < PosMax);
    pos1    = pos0 + PosW'(1);
    done    = take && (rclfr_pkg::TOTAL_W'(pos1) >= total);

    half_d  = half_q;
    pos_d   = pos_q;
    start_d = start_q;
    crc_d   = crc_q;
    res_o   = '0;

    if (is_byte) begin
      pos_d = pos0;
      if (pos0 == '0) begin
        start_d = time_us_i;
      end
      if (take) begin
        pos_d = done ? '0 : pos1;
        if (pos0 == PosW'(2)) begin
          crc_d = crc8_step(8'd0, rx_byte_i);
        end else if (pos0 > PosW'(2) && !done) begin
          crc_d = crc8_step(crc_q, rx_byte_i);
        end
        // last byte never enters the CRC; compare with the running value
        if (done && addr_q == cfg_i.own_address) begin
          half_d             = ~half_q;
          res_o.valid        = 1'b1;
          res_o.kind         = (crc_q == rx_byte_i) ? rclfr_pkg::KIND_OK
                                                    : rclfr_pkg::KIND_DROP;
          res_o.frame_type   = type_q;
          res_o.frame_length = len_q;
        end
      end
    end else if (acc_i) begin
      res_o.valid   = 1'b1;
      res_o.kind    = rclfr_pkg::KIND_READ;
      res_o.rd_zero = {3'd0, read_index_i} >= IdxLimit;
    end
  end

  assign wr_en_o   = is_byte && take;
  assign wr_addr_o = AddrW'(pos0) + (half_q ? HalfBase : '0);
  assign wr_data_o = rx_byte_i;
  // validated half is the one not being filled
  assign rd_en_o   = acc_i && (operation_i == rclfr_pkg::OP_READ) && !res_o.rd_zero;
  assign rd_addr_o = AddrW'(read_index_i) + (half_q ? '0 : HalfBase);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= 1'b0;
      pos_q   <= '0;
      start_q <= '0;
      crc_q   <= '0;
    end else begin
      half_q  <= half_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      crc_q   <= crc_d;
    end
  end

  // header shadows: address, length and type of the frame being filled
  always_ff @(posedge clk_i) begin
    if (wr_en_o) begin
      if (pos0 == PosW'(0)) addr_q <= rx_byte_i;
      if (pos0 == PosW'(1)) len_q  <= rx_byte_i;
      if (pos0 == PosW'(2)) type_q <= rx_byte_i;
    end
  end

endmodule

>>> hw/rtl/rc_link_frame_receiver.sv
// Top level of the RC link frame receiver.
`timescale 1ns / 1ps
//
//  channel   dir  handshake     word contents
//  item_i    in   valid/ready   operation, rx_byte, time_us, read_index
//  result_o  out  valid/ready   result_kind, frame_type, frame_length, read_data
//  cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i (no read-back)
//
//  One input word per cycle while item_i.ready is high. A byte word updates the
//  frame state, the CRC and the store write in the accept cycle; a read word
//  issues a store read and its data comes back in the following cycle from the
//  synchronous memory port. A result passes stage 1 and the output register.
//  Reset (async, active low) clears all control state, loads the register
//  defaults and clears the store through its per-entry valid bits at once.
//  A held result stage plus the output register let input words keep flowing
//  while result_o is stalled; item_i.ready drops only when both are full.

module rc_link_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  rclfr_in_if.sink                             item_i,
  rclfr_out_if.source                          result_o,
  input  logic                                 cfg_we_i,
  input  logic [rclfr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rclfr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AddrW = $clog2(2 * MAX_FRAME_BYTES);

  // configuration registers
  rclfr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address <= rclfr_pkg::OWN_ADDRESS_RESET;
      cfg_q.timeout_us  <= rclfr_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rclfr_pkg::CFG_OWN_ADDRESS: cfg_q.own_address <= cfg_data_i[7:0];
        rclfr_pkg::CFG_TIMEOUT:     cfg_q.timeout_us  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic             acc;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;
  rclfr_pkg::res_t  res;

  // stage 1: result waiting on store read data
  logic             s1_v_q;
  rclfr_pkg::res_t  s1_res_q;
  logic             s1_adv;

  // output register
  logic             out_v_q;
  logic [1:0]       out_kind_q;
  logic [7:0]       out_type_q, out_len_q, out_data_q;

  assign s1_adv       = s1_v_q && (!out_v_q || result_o.ready);
  assign item_i.ready = !s1_v_q || s1_adv;
  assign acc          = item_i.valid && item_i.ready;

  rclfr_parser #(
    .MaxFrameBytes (MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .operation_i  (item_i.operation),
    .rx_byte_i    (item_i.rx_byte),
    .time_us_i    (item_i.time_us),
    .read_index_i (item_i.read_index),
    .cfg_i        (cfg_q),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .res_o        (res)
  );

  rclfr_store #(
    .MaxFrameBytes (MAX_FRAME_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (acc) begin
      s1_v_q <= res.valid;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= 1'b1;
    end else if (result_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  // store read data is held while stage 1 waits: no new read issues until it moves
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_kind_q <= s1_res_q.kind;
      out_type_q <= s1_res_q.frame_type;
      out_len_q  <= s1_res_q.frame_length;
      out_data_q <= (s1_res_q.kind == rclfr_pkg::KIND_READ && !s1_res_q.rd_zero)
                    ? rd_data : 8'd0;
    end
  end

  assign result_o.valid        = out_v_q;
  assign result_o.result_kind  = out_kind_q;
  assign result_o.frame_type   = out_type_q;
  assign result_o.frame_length = out_len_q;
  assign result_o.read_data    = out_data_q;

  // a stalled stage 1 keeps its descriptor
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && out_v_q && !result_o.ready |=> s1_v_q && $stable(s1_res_q))
    else $error("stage 1 lost its result while stalled");

  // every accepted read word yields a read result in stage 1
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && item_i.operation == rclfr_pkg::OP_READ
      |=> s1_v_q && s1_res_q.kind == rclfr_pkg::KIND_READ)
    else $error("read word produced no read result");

  // store writes and reads come from different words
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("store write and read in the same cycle");

  // frame results never carry read data
  a_frame_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_kind_q != rclfr_pkg::KIND_READ |-> out_data_q == 8'd0)
    else $error("frame result carries nonzero read data");

endmodule
